[rtl/core/tscb_pkg.sv]
// Package for the timed sample capture buffer.
// Holds request codes, register indexes, sequencer states and default sizes.
// No dependencies.
package tscb_pkg;

   localparam int STORE_DEPTH_DEF = 4096;
   localparam int CHUNK_LIMIT_DEF = 32;

   // Keys at or above this index cannot be armed.
   localparam logic [7:0] KEY_LIMIT = 8'd6;

   // Width of one sample and of one stored raw/filtered pair.
   localparam int SAMPLE_W = 16;
   localparam int PAIR_W   = 2 * SAMPLE_W;

   localparam logic CSR_KEY_SELECT       = 1'b0;
   localparam logic CSR_CAPTURE_DURATION = 1'b1;

   typedef enum logic [1:0] {
      REQ_ARM    = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_SCAN   = 2'd2,
      REQ_READ   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARM,
      ST_CANCEL,
      ST_SCAN_KEY,
      ST_SCAN_TIME,
      ST_SCAN_END,
      ST_RD_CHECK,
      ST_RD_REM,
      ST_RD_CNT,
      ST_RD_ISSUE,
      ST_RD_OUT,
      ST_STATUS
   } state_type;

endpackage

[rtl/core/tscb_store.sv]
// Sample pair memory for the timed sample capture buffer.
// One write port, one read port with registered read data.
// Depends on tscb_pkg.
module tscb_store #(
   parameter int DEPTH = tscb_pkg::STORE_DEPTH_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [tscb_pkg::PAIR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [tscb_pkg::PAIR_W-1:0] rd_data
);

   logic [tscb_pkg::PAIR_W-1:0] mem_q [DEPTH];
   logic [tscb_pkg::PAIR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/timed_sample_capture_buffer.sv]
// Timed sample capture buffer: one request at a time, results are strobed on rsp_valid and
// cannot be held off by the receiver. A request is taken when start is high and busy is
// low; busy stays high until its last result has gone out. The key, time and read-range
// compares and subtractions go through one shared 32-bit subtractor stepped by the
// sequencer. An arm or cancel ends in a status result, as do a scan that is ignored,
// finds its key missing or captures (a capture also steps through the elapsed-time
// subtract and the duration compare) and a refused read; a read issues one memory
// read and gives one result per pair.
// Depends on tscb_pkg and tscb_store.
module timed_sample_capture_buffer #(
   parameter int STORE_DEPTH = tscb_pkg::STORE_DEPTH_DEF,
   parameter int CHUNK_LIMIT = tscb_pkg::CHUNK_LIMIT_DEF,
   parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_type,
   input  logic [31:0]      req_now_ms,
   input  logic [7:0]       req_keys_in_scan,
   input  logic [15:0]      req_raw_sample,
   input  logic [15:0]      req_filtered_sample,
   input  logic [15:0]      req_read_base,
   input  logic [7:0]       req_chunk_size,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_accepted,
   output logic             rsp_is_active,
   output logic [CNT_W-1:0] rsp_sample_total,
   output logic [31:0]      rsp_overflow_total,
   output logic [31:0]      rsp_capture_start,
   output logic             rsp_data_valid,
   output logic [15:0]      rsp_raw_value,
   output logic [15:0]      rsp_filtered_value,
   output logic             rsp_last
);

   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CHK_W = $clog2(CHUNK_LIMIT + 1);
   localparam int SW    = tscb_pkg::SAMPLE_W;

   tscb_pkg::state_type state_ff, state_in;

   // Configuration registers and values latched at arm.
   logic [7:0]       key_sel_ff;
   logic [31:0]      duration_ff;
   logic [7:0]       held_key_ff, held_key_in;
   logic [31:0]      held_dur_ff, held_dur_in;

   logic             active_ff, active_in;
   logic [31:0]      stamp_ff, stamp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      dropped_ff, dropped_in;
   logic             acc_ff, acc_in;

   // Request payload captured at the transfer.
   logic [31:0]      now_ff;
   logic [7:0]       kc_ff;
   logic [SW-1:0]    raw_ff;
   logic [SW-1:0]    filt_ff;
   logic [15:0]      si_ff;
   logic [7:0]       ms_ff;

   logic [31:0]      elapsed_ff, elapsed_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CHK_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] addr_ff, addr_in;

   // Shared subtract/compare unit.
   logic [31:0]      alu_a, alu_b;
   logic [32:0]      alu_diff;
   logic             alu_ge;

   logic [CHK_W-1:0] lim;
   logic             store_full;

   logic                        wr_en, rd_en;
   logic [tscb_pkg::PAIR_W-1:0] rd_data;

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_diff[32];

   assign store_full = (count_ff == CNT_W'(STORE_DEPTH));

   always_comb begin
      if (ms_ff == 8'd0 || ms_ff > 8'(CHUNK_LIMIT)) begin
         lim = CHK_W'(CHUNK_LIMIT);
      end else begin
         lim = ms_ff[CHK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tscb_pkg::ST_IDLE;
         key_sel_ff  <= 8'd0;
         duration_ff <= 32'd0;
         held_key_ff <= 8'd0;
         held_dur_ff <= 32'd0;
         active_ff   <= 1'b0;
         stamp_ff    <= 32'd0;
         count_ff    <= '0;
         dropped_ff  <= 32'd0;
         acc_ff      <= 1'b0;
         left_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         held_key_ff <= held_key_in;
         held_dur_ff <= held_dur_in;
         active_ff   <= active_in;
         stamp_ff    <= stamp_in;
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         acc_ff      <= acc_in;
         left_ff     <= left_in;
         if (csr_we) begin
            unique case (csr_index)
               tscb_pkg::CSR_KEY_SELECT:       key_sel_ff  <= csr_wdata[7:0];
               tscb_pkg::CSR_CAPTURE_DURATION: duration_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      rem_ff     <= rem_in;
      addr_ff    <= addr_in;
      if (state_ff == tscb_pkg::ST_IDLE && start) begin
         now_ff  <= req_now_ms;
         kc_ff   <= req_keys_in_scan;
         raw_ff  <= req_raw_sample;
         filt_ff <= req_filtered_sample;
         si_ff   <= req_read_base;
         ms_ff   <= req_chunk_size;
      end
   end

   always_comb begin
      state_in    = state_ff;
      held_key_in = held_key_ff;
      held_dur_in = held_dur_ff;
      active_in   = active_ff;
      stamp_in    = stamp_ff;
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      acc_in      = acc_ff;
      elapsed_in  = elapsed_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      addr_in     = addr_ff;
      alu_a       = 32'd0;
      alu_b       = 32'd0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;

      rsp_valid          = 1'b0;
      rsp_accepted       = 1'b1;
      rsp_data_valid     = 1'b0;
      rsp_raw_value      = '0;
      rsp_filtered_value = '0;
      rsp_last           = 1'b1;

      unique case (state_ff)
         tscb_pkg::ST_IDLE: begin
            if (start) begin
               acc_in = 1'b1;
               unique case (tscb_pkg::req_code_type'(req_type))
                  tscb_pkg::REQ_ARM:    state_in = tscb_pkg::ST_ARM;
                  tscb_pkg::REQ_CANCEL: state_in = tscb_pkg::ST_CANCEL;
                  tscb_pkg::REQ_SCAN:   state_in = tscb_pkg::ST_SCAN_KEY;
                  tscb_pkg::REQ_READ:   state_in = tscb_pkg::ST_RD_CHECK;
                  default:              state_in = tscb_pkg::ST_IDLE;
               endcase
            end
         end
         tscb_pkg::ST_ARM: begin
            if (key_sel_ff >= tscb_pkg::KEY_LIMIT || duration_ff == 32'd0) begin
               acc_in = 1'b0;
            end else begin
               active_in   = 1'b1;
               held_key_in = key_sel_ff;
               held_dur_in = duration_ff;
               stamp_in    = 32'd0;
               count_in    = '0;
               dropped_in  = 32'd0;
            end
            state_in = tscb_pkg::ST_STATUS;
         end
         tscb_pkg::ST_CANCEL: begin
            active_in = 1'b0;
            state_in  = tscb_pkg::ST_STATUS;
         end
         tscb_pkg::ST_SCAN_KEY: begin
            alu_a = {24'd0, held_key_ff};
            alu_b = {24'd0, kc_ff};
            if (!active_ff) begin
               state_in = tscb_pkg::ST_STATUS;
            end else if (alu_ge) begin
               // The captured key is missing from this scan.
               active_in = 1'b0;
               state_in  = tscb_pkg::ST_STATUS;
            end else begin
               if (count_ff == '0) begin
                  stamp_in = now_ff;
               end
               if (store_full) begin
                  dropped_in = dropped_ff + 32'd1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = tscb_pkg::ST_SCAN_TIME;
            end
         end
         tscb_pkg::ST_SCAN_TIME: begin
            alu_a      = now_ff;
            alu_b      = stamp_ff;
            elapsed_in = alu_diff[31:0];
            state_in   = tscb_pkg::ST_SCAN_END;
         end
         tscb_pkg::ST_SCAN_END: begin
            alu_a = elapsed_ff;
            alu_b = held_dur_ff;
            if (alu_ge) begin
               active_in = 1'b0;
            end
            state_in = tscb_pkg::ST_STATUS;
         end
         tscb_pkg::ST_RD_CHECK: begin
            alu_a = {16'd0, si_ff};
            alu_b = 32'(count_ff);
            if (alu_ge) begin
               state_in = tscb_pkg::ST_STATUS;
            end else begin
               state_in = tscb_pkg::ST_RD_REM;
            end
         end
         tscb_pkg::ST_RD_REM: begin
            alu_a    = 32'(count_ff);
            alu_b    = {16'd0, si_ff};
            rem_in   = alu_diff[CNT_W-1:0];
            addr_in  = si_ff[IDX_W-1:0];
            state_in = tscb_pkg::ST_RD_CNT;
         end
         tscb_pkg::ST_RD_CNT: begin
            alu_a = 32'(rem_ff);
            alu_b = 32'(lim);
            if (alu_ge) begin
               left_in = lim;
            end else begin
               left_in = rem_ff[CHK_W-1:0];
            end
            state_in = tscb_pkg::ST_RD_ISSUE;
         end
         tscb_pkg::ST_RD_ISSUE: begin
            rd_en    = 1'b1;
            state_in = tscb_pkg::ST_RD_OUT;
         end
         tscb_pkg::ST_RD_OUT: begin
            rsp_valid          = 1'b1;
            rsp_data_valid     = 1'b1;
            rsp_raw_value      = rd_data[SW-1:0];
            rsp_filtered_value = rd_data[2*SW-1:SW];
            rsp_last           = (left_ff == CHK_W'(1));
            if (left_ff == CHK_W'(1)) begin
               state_in = tscb_pkg::ST_IDLE;
            end else begin
               left_in  = left_ff - CHK_W'(1);
               addr_in  = addr_ff + IDX_W'(1);
               state_in = tscb_pkg::ST_RD_ISSUE;
            end
         end
         tscb_pkg::ST_STATUS: begin
            rsp_valid    = 1'b1;
            rsp_accepted = acc_ff;
            state_in     = tscb_pkg::ST_IDLE;
         end
         default: begin
            state_in = tscb_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != tscb_pkg::ST_IDLE);
   assign rsp_is_active      = active_ff;
   assign rsp_sample_total   = count_ff;
   assign rsp_overflow_total = dropped_ff;
   assign rsp_capture_start  = stamp_ff;

   tscb_store #(
      .DEPTH (STORE_DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({filt_ff, raw_ff}),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobed while idle");

   a_take_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not start the sequencer");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("block still busy after the last result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_sample_total <= CNT_W'(STORE_DEPTH))
      else $error("stored sample count beyond store depth");

   a_data_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_data_valid |-> rsp_valid)
      else $error("read data flagged without a result strobe");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for timed_sample_capture_buffer: directed corner cases, then random
// capture sessions checked against a behavioral shadow.
// Depends on tscb_pkg and the block's RTL.
module tb;

   localparam int DEPTH       = tscb_pkg::STORE_DEPTH_DEF;
   localparam int CHUNK       = tscb_pkg::CHUNK_LIMIT_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;
   localparam int SESSION_ITEMS = 100;

   typedef struct packed {
      tscb_pkg::req_code_type kind;
      logic [31:0]  now_ms;
      logic [7:0]   keys_in_scan;
      logic [15:0]  raw_sample;
      logic [15:0]  filtered_sample;
      logic [15:0]  read_base;
      logic [7:0]   chunk_size;
   } capture_request_type;

   typedef struct packed {
      logic        accepted;
      logic        is_active;
      logic [12:0] sample_total;
      logic [31:0] overflow_total;
      logic [31:0] capture_start;
      logic        data_valid;
      logic [15:0] raw_value;
      logic [15:0] filtered_value;
      logic        last;
   } capture_report_type;

   // Shadow of the capture state; predicts the reports of each request at its transfer.
   class capture_shadow_type;
      logic [7:0]  key_select;
      logic [31:0] duration;
      logic        active;
      logic [7:0]  held_key;
      logic [31:0] held_duration;
      logic [31:0] start_stamp;
      logic [12:0] stored_count;
      logic [31:0] dropped_count;
      logic [15:0] raw_mem [DEPTH];
      logic [15:0] filtered_mem [DEPTH];
      capture_report_type pending_reports [$];
      int mismatches;

      function new();
         key_select    = '0;
         duration      = '0;
         active        = 1'b0;
         held_key      = '0;
         held_duration = '0;
         start_stamp   = '0;
         stored_count  = '0;
         dropped_count = '0;
         mismatches    = 0;
      endfunction

      function void set_register(logic idx, logic [31:0] value);
         if (idx == tscb_pkg::CSR_KEY_SELECT) begin
            key_select = value[7:0];
         end else begin
            duration = value;
         end
      endfunction

      function capture_report_type status(logic acc, logic dv, logic [15:0] rv,
                                          logic [15:0] fv, logic lst);
         capture_report_type rep;
         rep.accepted       = acc;
         rep.is_active      = active;
         rep.sample_total   = stored_count;
         rep.overflow_total = dropped_count;
         rep.capture_start  = start_stamp;
         rep.data_valid     = dv;
         rep.raw_value      = rv;
         rep.filtered_value = fv;
         rep.last           = lst;
         return rep;
      endfunction

      function void note_request(capture_request_type rq);
         logic [31:0] elapsed;
         int unsigned first;
         int unsigned chunk;
         int unsigned count;
         case (rq.kind)
            tscb_pkg::REQ_ARM: begin
               if (key_select >= tscb_pkg::KEY_LIMIT || duration == 0) begin
                  pending_reports.push_back(status(1'b0, 1'b0, '0, '0, 1'b1));
               end else begin
                  active        = 1'b1;
                  held_key      = key_select;
                  held_duration = duration;
                  start_stamp   = '0;
                  stored_count  = '0;
                  dropped_count = '0;
                  pending_reports.push_back(status(1'b1, 1'b0, '0, '0, 1'b1));
               end
            end
            tscb_pkg::REQ_CANCEL: begin
               active = 1'b0;
               pending_reports.push_back(status(1'b1, 1'b0, '0, '0, 1'b1));
            end
            tscb_pkg::REQ_SCAN: begin
               if (active) begin
                  if (held_key >= rq.keys_in_scan) begin
                     active = 1'b0;
                  end else begin
                     if (stored_count == 0) start_stamp = rq.now_ms;
                     if (stored_count < DEPTH) begin
                        raw_mem[stored_count]      = rq.raw_sample;
                        filtered_mem[stored_count] = rq.filtered_sample;
                        stored_count++;
                     end else begin
                        dropped_count++;
                     end
                     // Elapsed time is taken modulo 2^32 so a wrap of the clock is harmless.
                     elapsed = rq.now_ms - start_stamp;
                     if (elapsed >= held_duration) active = 1'b0;
                  end
               end
               pending_reports.push_back(status(1'b1, 1'b0, '0, '0, 1'b1));
            end
            default: begin
               first = 32'(rq.read_base);
               if (first >= stored_count) begin
                  pending_reports.push_back(status(1'b1, 1'b0, '0, '0, 1'b1));
               end else begin
                  chunk = (rq.chunk_size == 0 || rq.chunk_size > CHUNK) ? CHUNK
                                                                        : 32'(rq.chunk_size);
                  count = 32'(stored_count) - first;
                  if (count > chunk) count = chunk;
                  for (int i = 0; i < count; i++) begin
                     pending_reports.push_back(status(1'b1, 1'b1, raw_mem[first + i],
                                                      filtered_mem[first + i],
                                                      i + 1 == count));
                  end
               end
            end
         endcase
      endfunction

      function string describe(capture_report_type r);
         return $sformatf({"acc=%0b act=%0b total=%0d ovf=%0d start=%h dv=%0b raw=%h ",
                           "filt=%h last=%0b"}, r.accepted, r.is_active, r.sample_total,
                          r.overflow_total, r.capture_start, r.data_valid, r.raw_value,
                          r.filtered_value, r.last);
      endfunction

      function void check_report(capture_report_type got);
         capture_report_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", describe(got));
            return;
         end
         want = pending_reports.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch\n  expected %s\n  actual   %s",
                        describe(want), describe(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = tscb_pkg::REQ_ARM;
   logic [31:0] req_now_ms = '0;
   logic [7:0]  req_keys_in_scan = '0;
   logic [15:0] req_raw_sample = '0;
   logic [15:0] req_filtered_sample = '0;
   logic [15:0] req_read_base = '0;
   logic [7:0]  req_chunk_size = '0;
   logic        csr_we = 1'b0;
   logic        csr_index = tscb_pkg::CSR_KEY_SELECT;
   logic [31:0] csr_wdata = '0;
   logic        rsp_valid;
   logic        rsp_accepted;
   logic        rsp_is_active;
   logic [12:0] rsp_sample_total;
   logic [31:0] rsp_overflow_total;
   logic [31:0] rsp_capture_start;
   logic        rsp_data_valid;
   logic [15:0] rsp_raw_value;
   logic [15:0] rsp_filtered_value;
   logic        rsp_last;

   capture_report_type observed;
   capture_shadow_type shadow;
   int                 quiet_cycles = 0;
   int                 calm_left = 0;

   timed_sample_capture_buffer u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_now_ms          (req_now_ms),
      .req_keys_in_scan    (req_keys_in_scan),
      .req_raw_sample      (req_raw_sample),
      .req_filtered_sample (req_filtered_sample),
      .req_read_base       (req_read_base),
      .req_chunk_size      (req_chunk_size),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_is_active       (rsp_is_active),
      .rsp_sample_total    (rsp_sample_total),
      .rsp_overflow_total  (rsp_overflow_total),
      .rsp_capture_start   (rsp_capture_start),
      .rsp_data_valid      (rsp_data_valid),
      .rsp_raw_value       (rsp_raw_value),
      .rsp_filtered_value  (rsp_filtered_value),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign observed = {rsp_accepted, rsp_is_active, rsp_sample_total, rsp_overflow_total,
                      rsp_capture_start, rsp_data_valid, rsp_raw_value, rsp_filtered_value,
                      rsp_last};

   always @(posedge clock) begin
      if (!reset && rsp_valid) shadow.check_report(observed);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("timed_sample_capture_buffer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Draws the idle gap before each request, with occasional stretches of back-to-back requests.
   function automatic int draw_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 24);
      return $urandom_range(0, 6);
   endfunction

   function automatic capture_request_type random_request(input tscb_pkg::req_code_type kind);
      capture_request_type rq;
      rq.kind            = kind;
      rq.now_ms          = $urandom;
      rq.keys_in_scan    = 8'($urandom);
      rq.raw_sample      = 16'($urandom);
      rq.filtered_sample = 16'($urandom);
      rq.read_base       = 16'($urandom);
      rq.chunk_size      = 8'($urandom);
      return rq;
   endfunction

   task automatic send_request(input capture_request_type rq);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type            <= rq.kind;
      req_now_ms          <= rq.now_ms;
      req_keys_in_scan    <= rq.keys_in_scan;
      req_raw_sample      <= rq.raw_sample;
      req_filtered_sample <= rq.filtered_sample;
      req_read_base       <= rq.read_base;
      req_chunk_size      <= rq.chunk_size;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      shadow.note_request(rq);
   endtask

   task automatic send_plain(input tscb_pkg::req_code_type kind);
      send_request(random_request(kind));
   endtask

   task automatic send_scan(input logic [31:0] now, input logic [7:0] keys);
      capture_request_type rq;
      rq              = random_request(tscb_pkg::REQ_SCAN);
      rq.now_ms       = now;
      rq.keys_in_scan = keys;
      send_request(rq);
   endtask

   task automatic send_read(input logic [15:0] first, input logic [7:0] limit);
      capture_request_type rq;
      rq            = random_request(tscb_pkg::REQ_READ);
      rq.read_base  = first;
      rq.chunk_size = limit;
      send_request(rq);
   endtask

   // Waits until every outstanding result has arrived and the block is free again.
   task automatic settle();
      start <= 1'b0;
      while (shadow.pending_reports.size() != 0 || busy) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      shadow.set_register(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] wall_ms;
      logic [31:0] word;
      int          sent;
      int          pick;

      shadow = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Corner cases from reset: empty store, zero duration, idle scan and cancel.
      send_read(16'd0, 8'd0);
      send_plain(tscb_pkg::REQ_ARM);
      send_scan(32'd0, 8'd255);
      send_plain(tscb_pkg::REQ_CANCEL);
      settle();
      write_reg(tscb_pkg::CSR_KEY_SELECT, 32'd6);
      write_reg(tscb_pkg::CSR_CAPTURE_DURATION, 32'd5);
      send_plain(tscb_pkg::REQ_ARM);
      settle();
      write_reg(tscb_pkg::CSR_KEY_SELECT, 32'hFFFF_FFFF);
      send_plain(tscb_pkg::REQ_ARM);
      settle();
      write_reg(tscb_pkg::CSR_KEY_SELECT, 32'd5);
      write_reg(tscb_pkg::CSR_CAPTURE_DURATION, 32'd1000);
      send_plain(tscb_pkg::REQ_ARM);
      send_scan(32'd100, 8'd5);
      send_plain(tscb_pkg::REQ_ARM);
      send_scan(32'hFFFF_FFF0, 8'd6);
      send_scan(32'h0000_0005, 8'd255);
      send_plain(tscb_pkg::REQ_ARM);
      send_scan(32'h8000_0000, 8'd6);
      // New settings must not disturb the capture already running.
      settle();
      write_reg(tscb_pkg::CSR_KEY_SELECT, 32'd0);
      write_reg(tscb_pkg::CSR_CAPTURE_DURATION, 32'd1);
      send_scan(32'h8000_0000 + 32'd999, 8'd6);
      send_scan(32'h8000_0000 + 32'd1000, 8'd200);
      send_read(16'd0, 8'd0);
      send_read(16'd2, 8'd255);
      send_read(16'd3, 8'd1);
      send_read(16'hFFFF, 8'hFF);
      send_plain(tscb_pkg::REQ_ARM);
      send_scan(32'd7, 8'd1);
      send_scan(32'd8, 8'd1);
      send_scan(32'd9, 8'd1);
      send_plain(tscb_pkg::REQ_CANCEL);

      // Random capture sessions, each under a fresh configuration.
      wall_ms = $urandom;
      sent    = 0;
      while (sent < SESSION_ITEMS) begin
         settle();
         word = $urandom;
         case ($urandom_range(0, 7))
            0:       word[7:0] = 8'd6;
            1:       word[7:0] = 8'($urandom_range(7, 255));
            default: word[7:0] = 8'($urandom_range(0, 5));
         endcase
         write_reg(tscb_pkg::CSR_KEY_SELECT, word);
         case ($urandom_range(0, 7))
            0:       word = 32'd0;
            1:       word = 32'd1;
            2:       word = 32'hFFFF_FFFF;
            3:       word = $urandom;
            default: word = $urandom_range(2, 80);
         endcase
         write_reg(tscb_pkg::CSR_CAPTURE_DURATION, word);
         send_plain(tscb_pkg::REQ_ARM);
         sent++;
         repeat ($urandom_range(8, 16)) begin
            pick = $urandom_range(0, 99);
            sent++;
            if (pick < 60) begin
               wall_ms += $urandom_range(0, 12);
               send_scan((pick < 3) ? $urandom : wall_ms,
                         (pick < 8) ? 8'($urandom)
                                    : 8'($urandom_range(shadow.held_key + 1, 255)));
            end else if (pick < 82) begin
               send_read((pick < 66) ? 16'($urandom)
                                     : 16'($urandom_range(0, shadow.stored_count)),
                         (pick < 70) ? 8'($urandom) : 8'($urandom_range(0, 40)));
            end else if (pick < 90) begin
               send_plain(tscb_pkg::REQ_CANCEL);
            end else begin
               send_plain(tscb_pkg::REQ_ARM);
            end
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending_reports.size() == 0) begin
         $display("timed_sample_capture_buffer regression: pass");
      end else begin
         $display("timed_sample_capture_buffer regression: fail");
      end
      $finish;
   end

endmodule

[timed_sample_capture_buffer.f]
rtl/core/tscb_pkg.sv
rtl/core/tscb_store.sv
rtl/core/timed_sample_capture_buffer.sv
sim/tb.sv
